@@ rtl/core/skvb_pkg.sv @@
`default_nettype none
package skvb_pkg;

    localparam int CAPACITY_DEF   = 32;
    localparam int BUCKETS_DEF    = 8;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam int OPCODE_W = 2;
    localparam int FIELD_W  = 32;
    localparam int COUNT_W  = 6;
    localparam int STATUS_W = 2;

    localparam int S_TDATA_W = 104;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 3;

    localparam logic [OPCODE_W-1:0] OP_LOOKUP     = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_INSERT     = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_SCAN_FROM  = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_SCAN_RANGE = 2'd3;

    localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NONE = 2'd2;

    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

endpackage
`default_nettype wire

@@ rtl/core/sorted_key_value_block_unit.sv @@
`default_nettype none
// Channel | Dir | Ports                     | Payload
// s_      | in  | s_tvalid/s_tready/s_tdata | opcode, key, item_value, end_key, max_count
// m_      | out | m_tvalid/m_tready/m_tdata | out_value; m_tuser hit, status; m_tlast last
// One request at a time; s_tready is high only while the sequencer is idle.
// Each entry is read from memory, then checked by the shared comparator: the search walks
// entries (S_SRD, S_SCMP), insert shifts entries up (S_SHR, S_SHW) before writing, lookup
// reads then checks, scans read and check each value; each result waits in S_OUT for m_tready.
// Synchronous active-low reset empties the table at once; no clearing pass.
// A stalled m_ side holds the sequencer in place.
module sorted_key_value_block_unit #(
    parameter int CAPACITY   = skvb_pkg::CAPACITY_DEF,
    parameter int BUCKETS    = skvb_pkg::BUCKETS_DEF,
    parameter int KEY_BITS   = skvb_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = skvb_pkg::VALUE_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [1:0] opcode, [33:2] key, [65:34] item_value, [97:66] end_key, [103:98] max_count
    input  wire logic [skvb_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [31:0] out_value
    output logic      [skvb_pkg::M_TDATA_W-1:0]  m_tdata,
    // [0] hit, [2:1] status
    output logic      [skvb_pkg::M_TUSER_W-1:0]  m_tuser,
    output logic                                 m_tlast
);

    localparam int AW = $clog2(CAPACITY);

    logic                                wr_en;
    logic [AW-1:0]                       wr_addr, rd_addr;
    logic [KEY_BITS-1:0]                 wr_key, rd_key, cmp_b;
    logic [VALUE_BITS-1:0]               wr_val, rd_val;
    skvb_pkg::cmp_res_t                  cmp_res;
    logic                                hit;
    logic [skvb_pkg::STATUS_W-1:0]       status;

    skvb_mem #(
        .DEPTH(CAPACITY), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS), .AW(AW)
    ) u_mem (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_key(wr_key),
        .wr_val(wr_val), .rd_addr(rd_addr), .rd_key(rd_key), .rd_val(rd_val)
    );

    skvb_key_cmp #(.KEY_BITS(KEY_BITS)) u_cmp (
        .a(rd_key), .b(cmp_b), .res(cmp_res)
    );

    skvb_seq #(
        .CAPACITY(CAPACITY), .BUCKETS(BUCKETS), .KEY_BITS(KEY_BITS),
        .VALUE_BITS(VALUE_BITS), .AW(AW)
    ) u_seq (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_opcode(s_tdata[1:0]), .in_key(s_tdata[33:2]), .in_value(s_tdata[65:34]),
        .in_end_key(s_tdata[97:66]), .in_max_count(s_tdata[103:98]),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_value(m_tdata),
        .out_hit(hit), .out_status(status), .out_last(m_tlast),
        .mem_wr_en(wr_en), .mem_wr_addr(wr_addr), .mem_wr_key(wr_key),
        .mem_wr_val(wr_val), .mem_rd_addr(rd_addr), .mem_rd_key(rd_key),
        .mem_rd_val(rd_val), .cmp_b(cmp_b), .cmp_res(cmp_res)
    );

    assign m_tuser = {status, hit};

endmodule
`default_nettype wire

@@ rtl/core/skvb_mem.sv @@
`default_nettype none
module skvb_mem #(
    parameter int DEPTH      = skvb_pkg::CAPACITY_DEF,
    parameter int KEY_BITS   = skvb_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = skvb_pkg::VALUE_BITS_DEF,
    parameter int AW         = $clog2(DEPTH)
) (
    input  wire logic                  aclk,
    input  wire logic                  wr_en,
    input  wire logic [AW-1:0]         wr_addr,
    input  wire logic [KEY_BITS-1:0]   wr_key,
    input  wire logic [VALUE_BITS-1:0] wr_val,
    input  wire logic [AW-1:0]         rd_addr,
    output logic      [KEY_BITS-1:0]   rd_key,
    output logic      [VALUE_BITS-1:0] rd_val
);

    logic [KEY_BITS-1:0]   key_mem [DEPTH];
    logic [VALUE_BITS-1:0] val_mem [DEPTH];
    logic [KEY_BITS-1:0]   rd_key_reg;
    logic [VALUE_BITS-1:0] rd_val_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            key_mem[wr_addr] <= wr_key;
            val_mem[wr_addr] <= wr_val;
        end
    end

    always_ff @(posedge aclk) begin
        rd_key_reg <= key_mem[rd_addr];
        rd_val_reg <= val_mem[rd_addr];
    end

    assign rd_key = rd_key_reg;
    assign rd_val = rd_val_reg;

endmodule
`default_nettype wire

@@ rtl/core/skvb_key_cmp.sv @@
`default_nettype none
module skvb_key_cmp #(
    parameter int KEY_BITS = skvb_pkg::KEY_BITS_DEF
) (
    input  wire logic [KEY_BITS-1:0] a,
    input  wire logic [KEY_BITS-1:0] b,
    output skvb_pkg::cmp_res_t       res
);

    assign res.lt = (a < b);
    assign res.eq = (a == b);

endmodule
`default_nettype wire

@@ rtl/core/skvb_seq.sv @@
`default_nettype none
module skvb_seq #(
    parameter int CAPACITY   = skvb_pkg::CAPACITY_DEF,
    parameter int BUCKETS    = skvb_pkg::BUCKETS_DEF,
    parameter int KEY_BITS   = skvb_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = skvb_pkg::VALUE_BITS_DEF,
    parameter int AW         = $clog2(CAPACITY)
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [skvb_pkg::OPCODE_W-1:0]       in_opcode,
    input  wire logic [skvb_pkg::FIELD_W-1:0]        in_key,
    input  wire logic [skvb_pkg::FIELD_W-1:0]        in_value,
    input  wire logic [skvb_pkg::FIELD_W-1:0]        in_end_key,
    input  wire logic [skvb_pkg::COUNT_W-1:0]        in_max_count,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic      [skvb_pkg::FIELD_W-1:0]        out_value,
    output logic                                     out_hit,
    output logic      [skvb_pkg::STATUS_W-1:0]       out_status,
    output logic                                     out_last,
    output logic                                     mem_wr_en,
    output logic      [AW-1:0]                       mem_wr_addr,
    output logic      [KEY_BITS-1:0]                 mem_wr_key,
    output logic      [VALUE_BITS-1:0]               mem_wr_val,
    output logic      [AW-1:0]                       mem_rd_addr,
    input  wire logic [KEY_BITS-1:0]                 mem_rd_key,
    input  wire logic [VALUE_BITS-1:0]               mem_rd_val,
    output logic      [KEY_BITS-1:0]                 cmp_b,
    input  skvb_pkg::cmp_res_t                       cmp_res
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SW = 4;

    localparam logic [SW-1:0] S_IDLE = 4'd0;
    localparam logic [SW-1:0] S_SRD  = 4'd1;
    localparam logic [SW-1:0] S_SCMP = 4'd2;
    localparam logic [SW-1:0] S_SEND = 4'd3;
    localparam logic [SW-1:0] S_SHR  = 4'd4;
    localparam logic [SW-1:0] S_SHW  = 4'd5;
    localparam logic [SW-1:0] S_INS  = 4'd6;
    localparam logic [SW-1:0] S_LRD  = 4'd7;
    localparam logic [SW-1:0] S_LCHK = 4'd8;
    localparam logic [SW-1:0] S_ERD  = 4'd9;
    localparam logic [SW-1:0] S_ECHK = 4'd10;
    localparam logic [SW-1:0] S_EEND = 4'd11;
    localparam logic [SW-1:0] S_OUT  = 4'd12;

    logic [SW-1:0]                     state_reg, state_next, ret_reg, ret_next;
    logic [skvb_pkg::OPCODE_W-1:0]     op_reg, op_next;
    logic [KEY_BITS-1:0]               k_reg, k_next, e_reg, e_next;
    logic [VALUE_BITS-1:0]             v_reg, v_next, pend_reg, pend_next;
    logic [skvb_pkg::COUNT_W-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]                     n_reg, n_next, per_reg, per_next;
    logic [BW-1:0]                     mod_reg, mod_next;
    logic [CW-1:0]                     p_reg, p_next, phase_reg, phase_next;
    logic [CW-1:0]                     lo_reg, lo_next, pos0_reg, pos0_next;
    logic [CW-1:0]                     pos_reg, pos_next, nemit_reg, nemit_next;
    logic                              found_reg, found_next, pend_ok_reg, pend_ok_next;
    logic                              ov_reg, ov_next, hit_reg, hit_next;
    logic                              last_reg, last_next;
    logic [skvb_pkg::FIELD_W-1:0]      oval_reg, oval_next;
    logic [skvb_pkg::STATUS_W-1:0]     stat_reg, stat_next;
    logic [KEY_BITS-1:0]               key_in, end_in;
    logic                              under_limit;

    assign key_in = KEY_BITS'(in_key);
    assign end_in = KEY_BITS'(in_end_key);
    assign in_ready = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign out_value = oval_reg;
    assign out_hit = hit_reg;
    assign out_status = stat_reg;
    assign out_last = last_reg;
    assign cmp_b = (state_reg == S_ECHK && op_reg == skvb_pkg::OP_SCAN_RANGE) ? e_reg : k_reg;
    assign under_limit = (op_reg == skvb_pkg::OP_SCAN_RANGE) ||
                         (8'(nemit_reg) < 8'(cnt_reg));

    always_comb begin
        state_next = state_reg;  ret_next = ret_reg;    op_next = op_reg;
        k_next = k_reg;          e_next = e_reg;        v_next = v_reg;
        pend_next = pend_reg;    cnt_next = cnt_reg;    n_next = n_reg;
        per_next = per_reg;      mod_next = mod_reg;    p_next = p_reg;
        phase_next = phase_reg;  lo_next = lo_reg;      pos0_next = pos0_reg;
        pos_next = pos_reg;      nemit_next = nemit_reg;
        found_next = found_reg;  pend_ok_next = pend_ok_reg;
        ov_next = ov_reg;        hit_next = hit_reg;    last_next = last_reg;
        oval_next = oval_reg;    stat_next = stat_reg;
        mem_wr_en = 1'b0;
        mem_wr_addr = pos_reg[AW-1:0];
        mem_wr_key = k_reg;
        mem_wr_val = v_reg;
        mem_rd_addr = p_reg[AW-1:0];

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    op_next = in_opcode;
                    k_next = key_in;
                    e_next = end_in;
                    v_next = VALUE_BITS'(in_value);
                    cnt_next = in_max_count;
                    p_next = '0;
                    phase_next = '0;
                    lo_next = '0;
                    pos0_next = n_reg;
                    found_next = 1'b0;
                    nemit_next = '0;
                    pend_ok_next = 1'b0;
                    // default answer: nothing found, single transaction
                    oval_next = '0;
                    hit_next = 1'b0;
                    stat_next = skvb_pkg::STAT_NONE;
                    last_next = 1'b1;
                    ret_next = S_IDLE;
                    state_next = S_SRD;
                    case (in_opcode)
                        skvb_pkg::OP_LOOKUP, skvb_pkg::OP_SCAN_FROM: begin
                            if (n_reg == '0) begin
                                ov_next = 1'b1;
                                state_next = S_OUT;
                            end
                        end
                        skvb_pkg::OP_INSERT: begin
                            if (32'(n_reg) >= 32'(CAPACITY)) begin
                                stat_next = skvb_pkg::STAT_FULL;
                                ov_next = 1'b1;
                                state_next = S_OUT;
                            end
                        end
                        default: begin
                            if (key_in > end_in) begin
                                ov_next = 1'b1;
                                state_next = S_OUT;
                            end
                        end
                    endcase
                end
            end
            S_SRD: begin
                state_next = (p_reg == n_reg) ? S_SEND : S_SCMP;
            end
            S_SCMP: begin
                // bucket starts sit at multiples of the span
                if (phase_reg == '0 && (cmp_res.lt || cmp_res.eq)) begin
                    lo_next = p_reg;
                end
                if (!found_reg && !cmp_res.lt) begin
                    pos0_next = p_reg;
                    found_next = 1'b1;
                end
                if (!cmp_res.lt && !cmp_res.eq) begin
                    state_next = S_SEND;
                end else begin
                    p_next = p_reg + 1'b1;
                    phase_next = (phase_reg == per_reg - 1'b1) ? '0 : phase_reg + 1'b1;
                    state_next = S_SRD;
                end
            end
            S_SEND: begin
                if (op_reg == skvb_pkg::OP_INSERT || op_reg == skvb_pkg::OP_SCAN_RANGE) begin
                    pos_next = pos0_reg;
                end else begin
                    pos_next = (lo_reg > pos0_reg) ? lo_reg : pos0_reg;
                end
                p_next = n_reg;
                case (op_reg)
                    skvb_pkg::OP_INSERT: state_next = S_SHR;
                    skvb_pkg::OP_LOOKUP: state_next = S_LRD;
                    default:             state_next = S_ERD;
                endcase
            end
            S_SHR: begin
                mem_rd_addr = AW'(p_reg - 1'b1);
                state_next = (p_reg > pos_reg) ? S_SHW : S_INS;
            end
            S_SHW: begin
                mem_wr_en = 1'b1;
                mem_wr_addr = p_reg[AW-1:0];
                mem_wr_key = mem_rd_key;
                mem_wr_val = mem_rd_val;
                p_next = p_reg - 1'b1;
                state_next = S_SHR;
            end
            S_INS: begin
                mem_wr_en = 1'b1;
                n_next = n_reg + 1'b1;
                if (32'(n_reg) + 32'd1 <= 32'(BUCKETS)) begin
                    per_next = CW'(1);
                end else if (mod_reg == '0) begin
                    per_next = per_reg + 1'b1;
                end
                mod_next = (mod_reg == BW'(BUCKETS - 1)) ? '0 : mod_reg + 1'b1;
                stat_next = skvb_pkg::STAT_OK;
                ov_next = 1'b1;
                state_next = S_OUT;
            end
            S_LRD: begin
                mem_rd_addr = pos_reg[AW-1:0];
                if (pos_reg >= n_reg) begin
                    ov_next = 1'b1;
                    state_next = S_OUT;
                end else begin
                    state_next = S_LCHK;
                end
            end
            S_LCHK: begin
                if (cmp_res.eq) begin
                    oval_next = skvb_pkg::FIELD_W'(mem_rd_val);
                    hit_next = 1'b1;
                    stat_next = skvb_pkg::STAT_OK;
                end
                ov_next = 1'b1;
                state_next = S_OUT;
            end
            S_ERD: begin
                mem_rd_addr = pos_reg[AW-1:0];
                state_next = (pos_reg < n_reg && under_limit) ? S_ECHK : S_EEND;
            end
            S_ECHK: begin
                if (op_reg != skvb_pkg::OP_SCAN_RANGE || cmp_res.lt || cmp_res.eq) begin
                    nemit_next = nemit_reg + 1'b1;
                    pos_next = pos_reg + 1'b1;
                    pend_next = mem_rd_val;
                    pend_ok_next = 1'b1;
                    state_next = S_ERD;
                    // one value held back so the final one can carry last
                    if (pend_ok_reg) begin
                        oval_next = skvb_pkg::FIELD_W'(pend_reg);
                        hit_next = 1'b1;
                        stat_next = skvb_pkg::STAT_OK;
                        last_next = 1'b0;
                        ov_next = 1'b1;
                        ret_next = S_ERD;
                        state_next = S_OUT;
                    end
                end else begin
                    state_next = S_EEND;
                end
            end
            S_EEND: begin
                if (pend_ok_reg) begin
                    oval_next = skvb_pkg::FIELD_W'(pend_reg);
                    hit_next = 1'b1;
                    stat_next = skvb_pkg::STAT_OK;
                end else begin
                    oval_next = '0;
                    hit_next = 1'b0;
                    stat_next = skvb_pkg::STAT_NONE;
                end
                last_next = 1'b1;
                ov_next = 1'b1;
                ret_next = S_IDLE;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_ready) begin
                    ov_next = 1'b0;
                    state_next = ret_reg;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg <= S_IDLE;
            n_reg <= '0;
            per_reg <= CW'(1);
            mod_reg <= '0;
            ov_reg <= 1'b0;
            found_reg <= 1'b0;
            pend_ok_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ret_reg <= ret_next;
            n_reg <= n_next;
            per_reg <= per_next;
            mod_reg <= mod_next;
            ov_reg <= ov_next;
            found_reg <= found_next;
            pend_ok_reg <= pend_ok_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg <= op_next;
        k_reg <= k_next;
        e_reg <= e_next;
        v_reg <= v_next;
        pend_reg <= pend_next;
        cnt_reg <= cnt_next;
        p_reg <= p_next;
        phase_reg <= phase_next;
        lo_reg <= lo_next;
        pos0_reg <= pos0_next;
        pos_reg <= pos_next;
        nemit_reg <= nemit_next;
        hit_reg <= hit_next;
        last_reg <= last_next;
        oval_reg <= oval_next;
        stat_reg <= stat_next;
    end

endmodule
`default_nettype wire

@@ rtl/core/skvb_checker.sv @@
`default_nettype none
module skvb_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [skvb_pkg::M_TDATA_W-1:0]  m_tdata,
    input wire logic [skvb_pkg::M_TUSER_W-1:0]  m_tuser,
    input wire logic                            m_tlast
);

    // one request in flight: no intake while a result is offered
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("intake while result pending");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("ready after accept");

    a_hit_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tuser[2:1] == skvb_pkg::STAT_OK))
        else $error("hit with bad status");

    a_miss_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |-> (m_tlast && m_tdata == '0))
        else $error("non-hit transaction not final or nonzero");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled result changed");

endmodule

bind sorted_key_value_block_unit skvb_checker u_skvb_checker (.*);
`default_nettype wire

@@ dv/sorted_key_value_block_unit_test.sv @@
`timescale 1ns / 100ps
module sorted_key_value_block_unit_test;

    localparam int CAP = skvb_pkg::CAPACITY_DEF;
    localparam int NB = skvb_pkg::BUCKETS_DEF;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [31:0] value;
        logic        hit;
        logic [1:0]  status;
        logic        last;
    } answer_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [skvb_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [skvb_pkg::M_TDATA_W-1:0] m_tdata;
    logic [skvb_pkg::M_TUSER_W-1:0] m_tuser;
    logic m_tlast;

    sorted_key_value_block_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always #5 aclk = ~aclk;

    // shadow table
    logic [31:0] tbl_key [CAP];
    logic [31:0] tbl_val [CAP];
    int unsigned tbl_n;
    logic [31:0] tbl_low, tbl_high;
    logic [31:0] tbl_idx [NB];

    logic [skvb_pkg::S_TDATA_W-1:0] pending_req[$];
    answer_t awaited[$];
    int errors = 0, mism = 0, n_sent = 0, n_answers = 0, n_ops[4] = '{0, 0, 0, 0};
    int n_full = 0, n_hits = 0;
    bit stim_done = 0;

    task automatic queue_answer(input answer_t a);
        awaited.insert(awaited.size(), a);
    endtask

    function automatic int unsigned slots_used();
        return tbl_n < NB ? tbl_n : NB;
    endfunction

    function automatic int unsigned span();
        int unsigned b;
        b = slots_used();
        return b == 0 ? 1 : (tbl_n + b - 1) / b;
    endfunction

    function automatic bit slot_ok(int unsigned i);
        return i < slots_used() && i * span() < tbl_n;
    endfunction

    task automatic search_window(input logic [31:0] k, output int unsigned lo,
                                 output int unsigned hi);
        int unsigned u, per;
        u = 0;
        per = span();
        while (u < NB && slot_ok(u) && tbl_idx[u] <= k) u++;
        if (u == 0) begin
            lo = 0;
            hi = per < tbl_n ? per : tbl_n;
        end else begin
            lo = (u - 1) * per;
            hi = u * per < tbl_n ? u * per : tbl_n;
        end
    endtask

    function automatic answer_t mk(logic [31:0] v, logic h, logic [1:0] st, logic l);
        answer_t a;
        a.value = v; a.hit = h; a.status = st; a.last = l;
        return a;
    endfunction

    task automatic emit_values(input int unsigned pos, input int unsigned lim,
                               input logic [31:0] e, input bit bounded);
        int n;
        answer_t a;
        n = 0;
        while (pos < tbl_n && n < lim) begin
            if (bounded && tbl_key[pos] > e) break;
            queue_answer(mk(tbl_val[pos], 1'b1, skvb_pkg::STAT_OK, 1'b0));
            n++; pos++;
        end
        if (n == 0) queue_answer(mk('0, 1'b0, skvb_pkg::STAT_NONE, 1'b1));
        else begin
            a = awaited.pop_back();
            a.last = 1'b1;
            queue_answer(a);
        end
    endtask

    task automatic predict_request(input logic [skvb_pkg::S_TDATA_W-1:0] d);
        logic [1:0] op;
        logic [31:0] k, v, e;
        int unsigned cnt, lo, hi, pos, i;
        bit found;
        op = d[1:0]; k = d[33:2]; v = d[65:34]; e = d[97:66]; cnt = d[103:98];
        n_ops[op]++;
        case (op)
            skvb_pkg::OP_LOOKUP: begin
                found = 0;
                if (tbl_n != 0 && k >= tbl_low) begin
                    search_window(k, lo, hi);
                    for (i = lo; i < hi; i++) begin
                        if (tbl_key[i] == k) begin
                            queue_answer(mk(tbl_val[i], 1'b1, skvb_pkg::STAT_OK, 1'b1));
                            found = 1;
                            n_hits++;
                            break;
                        end
                        if (tbl_key[i] > k) break;
                    end
                end
                if (!found) queue_answer(mk('0, 1'b0, skvb_pkg::STAT_NONE, 1'b1));
            end
            skvb_pkg::OP_INSERT: begin
                if (tbl_n >= CAP) begin
                    queue_answer(mk('0, 1'b0, skvb_pkg::STAT_FULL, 1'b1));
                    n_full++;
                end else begin
                    pos = 0;
                    while (pos < tbl_n && tbl_key[pos] < k) pos++;
                    for (i = tbl_n; i > pos; i--) begin
                        tbl_key[i] = tbl_key[i-1];
                        tbl_val[i] = tbl_val[i-1];
                    end
                    tbl_key[pos] = k;
                    tbl_val[pos] = v;
                    if (tbl_n == 0) begin
                        tbl_low = k; tbl_high = k;
                    end else begin
                        if (k > tbl_high) tbl_high = k;
                        if (k < tbl_low) tbl_low = k;
                    end
                    tbl_n++;
                    for (i = 0; i < NB; i++)
                        tbl_idx[i] = slot_ok(i) ? tbl_key[i * span()] : '1;
                    queue_answer(mk('0, 1'b0, skvb_pkg::STAT_OK, 1'b1));
                end
            end
            skvb_pkg::OP_SCAN_FROM: begin
                if (tbl_n == 0) emit_values(0, 0, '0, 0);
                else begin
                    search_window(k, lo, hi);
                    pos = lo;
                    while (pos < hi && tbl_key[pos] < k) pos++;
                    emit_values(pos, cnt, '0, 0);
                end
            end
            default: begin
                if (k > e) emit_values(0, 0, '0, 0);
                else begin
                    pos = 0;
                    while (pos < tbl_n && tbl_key[pos] < k) pos++;
                    emit_values(pos, CAP, e, 1);
                end
            end
        endcase
    endtask

    function automatic logic [skvb_pkg::S_TDATA_W-1:0] pack_req(logic [1:0] op,
            logic [31:0] k, logic [31:0] v, logic [31:0] e, logic [5:0] c);
        return {c, e, v, k, op};
    endfunction

    // keys drawn from a small pool so lookups and duplicates actually hit
    logic [31:0] key_pool[$];

    function automatic logic [31:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6 && key_pool.size() > 0) return key_pool[$urandom_range(0, key_pool.size()-1)];
        if (r == 6) return 32'hFFFF_FFFF;
        if (r == 7) return 32'h0;
        return $urandom();
    endfunction

    task automatic add_req(input logic [1:0] op, input logic [31:0] k, input logic [31:0] v,
                           input logic [31:0] e, input logic [5:0] c);
        pending_req.insert(pending_req.size(), pack_req(op, k, v, e, c));
        if (op == skvb_pkg::OP_INSERT) key_pool.insert(key_pool.size(), k);
    endtask

    initial begin
        int i, r, c;
        logic [31:0] k, e;
        for (i = 0; i < CAP; i++) begin tbl_key[i] = '0; tbl_val[i] = '0; end
        for (i = 0; i < NB; i++) tbl_idx[i] = '1;
        tbl_n = 0; tbl_low = '1; tbl_high = '0;

        // empty table cases, then four inserts with edge lookups and scans
        add_req(skvb_pkg::OP_LOOKUP, 32'h0, '1, '1, 6'd63);
        add_req(skvb_pkg::OP_SCAN_FROM, 32'h0, '0, '0, 6'd32);
        add_req(skvb_pkg::OP_SCAN_RANGE, 32'h0, '0, '1, 6'd0);
        add_req(skvb_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, 6'd63);
        add_req(skvb_pkg::OP_LOOKUP, 32'hFFFF_FFFF, '0, '0, 6'd0);
        add_req(skvb_pkg::OP_INSERT, 32'h0, 32'h0, '0, 6'd0);
        add_req(skvb_pkg::OP_INSERT, 32'h100, 32'hA5A5_5A5A, '0, 6'd0);
        add_req(skvb_pkg::OP_INSERT, 32'h100, 32'h5A5A_A5A5, '0, 6'd0); // equal key goes first
        add_req(skvb_pkg::OP_LOOKUP, 32'h100, '0, '0, 6'd0);
        add_req(skvb_pkg::OP_LOOKUP, 32'h50, '0, '0, 6'd0);
        add_req(skvb_pkg::OP_SCAN_FROM, 32'h1, '0, '0, 6'd0);          // zero count
        add_req(skvb_pkg::OP_SCAN_FROM, 32'h1, '0, '0, 6'd32);
        add_req(skvb_pkg::OP_SCAN_RANGE, 32'h200, '0, 32'h100, 6'd0);  // start above end
        add_req(skvb_pkg::OP_SCAN_RANGE, 32'h0, '0, 32'hFFFF_FFFF, 6'd1);
        add_req(skvb_pkg::OP_SCAN_RANGE, 32'h101, '0, 32'hFFFF_FFFE, 6'd1);
        // fill to full, then refused insert
        for (i = 0; i < CAP - 4; i++)
            add_req(skvb_pkg::OP_INSERT, $urandom(), $urandom(), $urandom(), 6'd0);
        add_req(skvb_pkg::OP_INSERT, 32'h7, 32'h7, '0, 6'd0);
        add_req(skvb_pkg::OP_SCAN_FROM, 32'h0, '0, '0, 6'd32);
        add_req(skvb_pkg::OP_SCAN_RANGE, 32'h0, '0, 32'hFFFF_FFFF, 6'd0);

        // random part: fresh table each time would need reset, so keep mixing
        for (i = 0; i < 234; i++) begin
            r = $urandom_range(0, 9);
            k = pick_key();
            e = ($urandom_range(0, 3) == 0) ? $urandom() : k + $urandom_range(0, 32'h4000_0000);
            if (e < k && $urandom_range(0, 1)) e = '1;
            c = $urandom_range(0, 3) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 8);
            if (r < 4)
                add_req(skvb_pkg::OP_LOOKUP, k, $urandom(), $urandom(), 6'($urandom()));
            else if (r < 5)
                add_req(skvb_pkg::OP_INSERT, k, $urandom(), $urandom(), 6'($urandom()));
            else if (r < 8)
                add_req(skvb_pkg::OP_SCAN_FROM, k, $urandom(), $urandom(), c[5:0]);
            else
                add_req(skvb_pkg::OP_SCAN_RANGE, k, $urandom(), e, 6'($urandom()));
        end
    end

    // set when the transaction on s_ was taken at the last rising edge
    bit in_taken = 1'b0;
    always @(posedge aclk) begin
        in_taken <= s_tvalid && s_tready;
    end

    // driver: bursts and gaps
    int burst_left = 0, gap_left = 0;
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && !in_taken) begin
                // hold the transaction
            end else if (pending_req.size() > 0 && gap_left == 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_req.pop_front();
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 8);
                end
                burst_left--;
                if (burst_left == 0) gap_left = $urandom_range(0, 3) == 0 ? 0 :
                                                $urandom_range(1, 60);
            end else begin
                s_tvalid <= 1'b0;
                s_tdata <= skvb_pkg::S_TDATA_W'({$urandom(), $urandom(), $urandom(),
                                                 $urandom()});
                if (gap_left > 0) gap_left--;
                if (pending_req.size() == 0) stim_done = 1;
            end
        end
    end

    // receiver stall pattern
    int rcv_phase = 0;
    always @(negedge aclk) begin
        rcv_phase <= rcv_phase + 1;
        case ((rcv_phase / 256) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= (rcv_phase % 5) != 0;
        endcase
    end

    // monitor
    int idle_cycles = 0;
    always @(posedge aclk) begin
        answer_t got, want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_request(s_tdata);
                n_sent++;
            end
            if (m_tvalid && m_tready) begin
                got = mk(m_tdata, m_tuser[0], m_tuser[2:1], m_tlast);
                n_answers++;
                if (awaited.size() == 0) begin
                    errors++;
                    if (mism++ < 10) $display("unexpected result %h", got);
                end else begin
                    want = awaited.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (mism++ < 10) begin
                            $display("mismatch: expected val=%h hit=%b st=%0d last=%b",
                                     want.value, want.hit, want.status, want.last);
                            $display("          got      val=%h hit=%b st=%0d last=%b",
                                     got.value, got.hit, got.status, got.last);
                        end
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        while (!(stim_done && awaited.size() == 0) && idle_cycles < WATCHDOG_LIMIT)
            @(posedge aclk);
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", awaited.size());
            $display("FAILURE");
            $finish;
        end else begin
            repeat (200) @(posedge aclk);
            $display("%0d requests (lookup %0d, insert %0d, scan-from %0d, range %0d), %0d results",
                     n_sent, n_ops[0], n_ops[1], n_ops[2], n_ops[3], n_answers);
            $display("%0d lookup hits, %0d refused inserts, %0d errors", n_hits, n_full, errors);
            if (errors == 0 && awaited.size() == 0) begin
                $display("SUCCESS");
            end else begin
                $display("FAILURE");
            end
            $finish;
        end
    end
endmodule
